>>> rtl/edf_pkg.sv
package edf_pkg;

  // Request modes as carried on in_mode, and the ack kind for an unknown mode
  localparam logic [2:0] MODE_CREATE = 3'd0;
  localparam logic [2:0] MODE_DELETE = 3'd1;
  localparam logic [2:0] MODE_TICK   = 3'd2;
  localparam logic [2:0] MODE_QUERY  = 3'd3;
  localparam logic [2:0] MODE_RESET  = 3'd4;
  localparam logic [2:0] ACK_UNKNOWN = 3'd5;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OVERDUE = 3'd1;
  localparam logic [2:0] ST_FAILED  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  localparam logic [7:0] BASE_PRIO_RST = 8'd15;

  // Step commands from the sequencer to the datapath
  typedef struct packed {
    logic load;  // capture request beat
    logic cmp;   // compare every cell against the request
    logic sel;   // encode rank, pick first match, build shift mask
    logic upd;   // apply table update and register the result
  } edf_cmd_t;

  // Fold a fill level into the 5-bit count fields
  function automatic logic [4:0] cnt5(input logic [31:0] v);
    return v[4:0];
  endfunction

endpackage

>>> rtl/edf_ctrl.sv
module edf_ctrl import edf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output edf_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_SEL  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = start ? S_CMP : S_IDLE;
      S_CMP:   state_nxt = S_SEL;
      S_SEL:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign cmd.load = start && (state_r == S_IDLE);
  assign cmd.cmp  = (state_r == S_CMP);
  assign cmd.sel  = (state_r == S_SEL);
  assign cmd.upd  = (state_r == S_UPD);

endmodule

>>> rtl/edf_dp.sv
module edf_dp import edf_pkg::*; #(
  parameter int ACTIVE_DEPTH  = 16,
  parameter int OVERDUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  edf_cmd_t    cmd,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_task_id,
  input  logic [31:0] in_creation_time,
  input  logic [31:0] in_relative_deadline,
  input  logic [31:0] in_current_time,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        out_valid,
  output logic [2:0]  out_ack_kind,
  output logic [2:0]  out_status,
  output logic [31:0] out_result_task_id,
  output logic [8:0]  out_assigned_priority,
  output logic [4:0]  out_active_count,
  output logic [4:0]  out_overdue_count,
  output logic [4:0]  out_killed_count,
  output logic        out_overdue_dropped
);

  localparam int AFW = $clog2(ACTIVE_DEPTH + 1);
  localparam int OFW = $clog2(OVERDUE_DEPTH + 1);
  localparam logic [ACTIVE_DEPTH-1:0] A_ONE = ACTIVE_DEPTH'(1);

  // Captured request
  logic [2:0]  mode_r;
  logic [31:0] tid_r;
  logic [31:0] dl_r;
  logic [31:0] now_r;

  // Cell rows
  logic [31:0] act_dl_r [ACTIVE_DEPTH];
  logic [31:0] act_id_r [ACTIVE_DEPTH];
  logic [31:0] od_id_r  [OVERDUE_DEPTH];
  logic [AFW-1:0] act_fill_r, act_fill_nxt;
  logic [OFW-1:0] od_fill_r, od_fill_nxt;
  logic [7:0] base_r;

  // Compare stage
  logic [ACTIVE_DEPTH-1:0]  le_r, le_nxt;
  logic [ACTIVE_DEPTH-1:0]  am_r, am_nxt;
  logic [OVERDUE_DEPTH-1:0] om_r, om_nxt;
  logic exp_r, exp_nxt;

  // Select stage
  logic [AFW-1:0]          pos_r, pos_nxt;
  logic [ACTIVE_DEPTH-1:0] sh_r, sh_nxt;
  logic found_r, ohit_r;
  logic [ACTIVE_DEPTH+1:0] t_ext;
  logic [ACTIVE_DEPTH-1:0] first_m;

  // Result stage
  logic [2:0]  ack_nxt, status_nxt;
  logic [31:0] rid_nxt;
  logic [8:0]  prio_nxt;
  logic [4:0]  killed_nxt;
  logic        dropped_nxt;
  logic        act_full, od_full;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      tid_r  <= in_task_id;
      dl_r   <= in_creation_time + in_relative_deadline;
      now_r  <= in_current_time;
    end
  end

  always_comb begin
    for (int i = 0; i < ACTIVE_DEPTH; i++) begin
      le_nxt[i] = (i < int'(act_fill_r)) && (act_dl_r[i] <= dl_r);
      am_nxt[i] = (i < int'(act_fill_r)) && (act_id_r[i] == tid_r);
    end
    for (int i = 0; i < OVERDUE_DEPTH; i++) begin
      om_nxt[i] = (i < int'(od_fill_r)) && (od_id_r[i] == tid_r);
    end
    exp_nxt = (act_fill_r != '0) && (act_dl_r[0] <= now_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      le_r  <= le_nxt;
      am_r  <= am_nxt;
      om_r  <= om_nxt;
      exp_r <= exp_nxt;
    end
  end

  // le_r is a prefix of ones; rank is where the prefix ends
  assign t_ext   = {1'b0, le_r, 1'b1};
  assign first_m = am_r & (~am_r + A_ONE);

  always_comb begin
    pos_nxt = '0;
    for (int j = 0; j <= ACTIVE_DEPTH; j++) begin
      if (t_ext[j] && !t_ext[j+1]) begin
        pos_nxt = pos_nxt | AFW'(j);
      end
    end
    if (mode_r == MODE_TICK) begin
      sh_nxt = exp_r ? '1 : '0;
    end else begin
      sh_nxt = ~(first_m - A_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      pos_r   <= pos_nxt;
      sh_r    <= sh_nxt;
      found_r <= |am_r;
      ohit_r  <= |om_r;
    end
  end

  assign act_full = (act_fill_r == AFW'(ACTIVE_DEPTH));
  assign od_full  = (od_fill_r == OFW'(OVERDUE_DEPTH));

  always_comb begin
    act_fill_nxt = act_fill_r;
    od_fill_nxt  = od_fill_r;
    ack_nxt      = mode_r;
    status_nxt   = ST_OK;
    rid_nxt      = '0;
    prio_nxt     = '0;
    killed_nxt   = '0;
    dropped_nxt  = 1'b0;
    case (mode_r)
      MODE_CREATE: begin
        if (act_full) begin
          status_nxt = ST_FULL;
        end else begin
          act_fill_nxt = act_fill_r + AFW'(1);
          rid_nxt      = tid_r;
          prio_nxt     = 9'(10'(base_r) + 10'(pos_r));
        end
      end
      MODE_DELETE: begin
        if (found_r) begin
          act_fill_nxt = act_fill_r - AFW'(1);
          rid_nxt      = tid_r;
        end else if (ohit_r) begin
          status_nxt = ST_OVERDUE;
          rid_nxt    = tid_r;
        end else begin
          status_nxt = ST_FAILED;
        end
      end
      MODE_TICK: begin
        if (exp_r) begin
          act_fill_nxt = act_fill_r - AFW'(1);
          if (od_full) begin
            dropped_nxt = 1'b1;
          end else begin
            od_fill_nxt = od_fill_r + OFW'(1);
          end
          rid_nxt    = act_id_r[0];
          killed_nxt = 5'd1;
        end else begin
          status_nxt = ST_NONE;
        end
      end
      MODE_QUERY: begin
        status_nxt = ST_OK;
      end
      MODE_RESET: begin
        killed_nxt   = cnt5(32'(act_fill_r));
        act_fill_nxt = '0;
        od_fill_nxt  = '0;
      end
      default: begin
        ack_nxt    = ACK_UNKNOWN;
        status_nxt = ST_FAILED;
      end
    endcase
  end

  // Cell rows: insert, close a gap, push overdue
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      case (mode_r)
        MODE_CREATE: begin
          if (!act_full) begin
            for (int i = 0; i < ACTIVE_DEPTH; i++) begin
              if (!le_r[i]) begin
                if (t_ext[i]) begin
                  act_dl_r[i] <= dl_r;
                  act_id_r[i] <= tid_r;
                end else begin
                  act_dl_r[i] <= act_dl_r[(i == 0) ? 0 : i - 1];
                  act_id_r[i] <= act_id_r[(i == 0) ? 0 : i - 1];
                end
              end
            end
          end
        end
        MODE_DELETE, MODE_TICK: begin
          for (int i = 0; i < ACTIVE_DEPTH; i++) begin
            if (sh_r[i]) begin
              act_dl_r[i] <= act_dl_r[(i + 1 < ACTIVE_DEPTH) ? i + 1 : i];
              act_id_r[i] <= act_id_r[(i + 1 < ACTIVE_DEPTH) ? i + 1 : i];
            end
          end
          if ((mode_r == MODE_TICK) && exp_r && !od_full) begin
            od_id_r[0] <= act_id_r[0];
            for (int i = 1; i < OVERDUE_DEPTH; i++) begin
              od_id_r[i] <= od_id_r[i - 1];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_fill_r <= '0;
      od_fill_r  <= '0;
      base_r     <= BASE_PRIO_RST;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      out_valid <= cmd.upd;
      if (cmd.upd) begin
        act_fill_r <= act_fill_nxt;
        od_fill_r  <= od_fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_ack_kind          <= ack_nxt;
      out_status            <= status_nxt;
      out_result_task_id    <= rid_nxt;
      out_assigned_priority <= prio_nxt;
      out_active_count      <= cnt5(32'(act_fill_nxt));
      out_overdue_count     <= cnt5(32'(od_fill_nxt));
      out_killed_count      <= killed_nxt;
      out_overdue_dropped   <= dropped_nxt;
    end
  end

endmodule

>>> rtl/edf_deadline_task_queue.sv
// Channel  | ports                                  | beat taken when
// ---------+----------------------------------------+--------------------------
// request  | start, busy, in_mode .. in_current_time| start high, busy low
// result   | out_valid, out_ack_kind .. out_overdue_| out_valid high (one cycle)
// config   | cfg_we, cfg_wdata                      | cfg_we high
//
// Every request passes through capture at the accepting edge, compare of all cells
// at once, encode rank / first match, then update of the cell rows and register
// the result. The result strobe is high once the update is registered; busy is
// low again in that same cycle, so the next request can be accepted while the
// strobe shows. While busy is high no new request is taken.
// Reset (rst_n low, synchronous) empties both stores and sets base priority
// to 15; table contents themselves are not cleared.
// The receiver cannot stall; out_valid is a single-cycle strobe.
module edf_deadline_task_queue import edf_pkg::*; #(
  parameter int ACTIVE_DEPTH  = 16,
  parameter int OVERDUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_task_id,
  input  logic [31:0] in_creation_time,
  input  logic [31:0] in_relative_deadline,
  input  logic [31:0] in_current_time,
  output logic        out_valid,
  output logic [2:0]  out_ack_kind,
  output logic [2:0]  out_status,
  output logic [31:0] out_result_task_id,
  output logic [8:0]  out_assigned_priority,
  output logic [4:0]  out_active_count,
  output logic [4:0]  out_overdue_count,
  output logic [4:0]  out_killed_count,
  output logic        out_overdue_dropped,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  edf_cmd_t cmd;

  // Sequencer: walks each beat through compare, select and update
  edf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath: sorted active cell row, overdue shift line, result register
  edf_dp #(
    .ACTIVE_DEPTH  (ACTIVE_DEPTH),
    .OVERDUE_DEPTH (OVERDUE_DEPTH)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .in_mode               (in_mode),
    .in_task_id            (in_task_id),
    .in_creation_time      (in_creation_time),
    .in_relative_deadline  (in_relative_deadline),
    .in_current_time       (in_current_time),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .out_valid             (out_valid),
    .out_ack_kind          (out_ack_kind),
    .out_status            (out_status),
    .out_result_task_id    (out_result_task_id),
    .out_assigned_priority (out_assigned_priority),
    .out_active_count      (out_active_count),
    .out_overdue_count     (out_overdue_count),
    .out_killed_count      (out_killed_count),
    .out_overdue_dropped   (out_overdue_dropped)
  );

endmodule

>>> rtl/edf_chk.sv
module edf_chk import edf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_ack_kind,
  input logic [4:0] out_active_count,
  input logic [4:0] out_overdue_count
);

  // An accepted beat locks the request side
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // Each accepted beat is followed by its result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("result strobe missing after accepted beat");

  // Result strobe only shows once the request side is free again
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // A reset request leaves both stores empty
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_ack_kind == MODE_RESET)) |->
      (out_active_count == 5'd0) && (out_overdue_count == 5'd0))
    else $error("reset request left entries behind");

  // Coming out of reset nothing is pending
  a_post_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (!out_valid && !busy))
    else $error("activity right after reset");

endmodule

bind edf_deadline_task_queue edf_chk u_edf_chk (.*);
